>>> design/aabb_circle_collision_test_unit_assert.svh
// Assertion macros for the checker file of the collision unit.
// Each macro expects clk_i and rst_ni in scope.
`ifndef AABB_CIRCLE_COLLISION_TEST_UNIT_ASSERT_SVH
`define AABB_CIRCLE_COLLISION_TEST_UNIT_ASSERT_SVH

// Same-cycle implication.
`define ACT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ACT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/aabbc_pkg.sv
`default_nettype none

package aabbc_pkg;

  localparam int unsigned InDataW  = 288;
  localparam int unsigned OutDataW = 104;

  // Normal magnitudes, Q16.16
  localparam logic signed [17:0] NormUnit = 18'sd65536;
  localparam logic signed [17:0] NormDiag = 18'sd46341;

  typedef struct packed {
    logic               cmd;
    logic signed [31:0] rect_x;
    logic signed [31:0] rect_y;
    logic        [30:0] rect_w;
    logic        [30:0] rect_h;
    logic signed [31:0] other_x;
    logic signed [31:0] other_y;
    logic        [30:0] other_w;
    logic        [30:0] other_h;
    logic        [30:0] circle_radius;
  } item_t;

  // Geometry stage result: everything but the circle distance test
  typedef struct packed {
    logic               pair;
    logic               near;      // both clamped deltas below the radius
    logic               pair_hit;
    logic        [31:0] ax;
    logic        [31:0] ay;
    logic        [31:0] rad;
    logic signed [17:0] nx;
    logic signed [17:0] ny;
    logic signed [31:0] pen_x;
    logic signed [31:0] pen_y;
  } geo_t;

  // Product stage result
  typedef struct packed {
    logic               pair;
    logic               near;
    logic               pair_hit;
    logic        [63:0] xx;
    logic        [63:0] yy;
    logic        [63:0] rr;
    logic signed [17:0] nx;
    logic signed [17:0] ny;
    logic signed [31:0] pen_x;
    logic signed [31:0] pen_y;
  } prod_t;

endpackage

`default_nettype wire

>>> design/aabbc_geom.sv
`default_nettype none

module aabbc_geom import aabbc_pkg::*; (
  input  item_t item_i,
  output geo_t  geo_o
);

  // All coordinates in Q.17 (doubled) so that half sizes are exact
  logic signed [34:0] rx, ry, ox, oy, hw, hh, ohw, ohh, rad;
  logic signed [34:0] x_hi, x_lo, y_hi, y_lo, cx, cy, cx_c, cy_c;
  logic signed [34:0] dx, dy, adx, ady, sx, sy, asx, asy;
  logic signed [34:0] pen_cx, pen_cy, pen_px, pen_py, pen_x_raw, pen_y_raw;
  logic signed [17:0] sgn_dx, sgn_dy;

  function automatic logic signed [31:0] sat_half(input logic signed [34:0] v);
    logic signed [34:0] h;
    h = v >>> 1;
    if (h > 35'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end else if (h < -35'sd2147483648) begin
      return 32'sh8000_0000;
    end else begin
      return h[31:0];
    end
  endfunction

  assign rx  = {{2{item_i.rect_x[31]}}, item_i.rect_x, 1'b0};
  assign ry  = {{2{item_i.rect_y[31]}}, item_i.rect_y, 1'b0};
  assign ox  = {{2{item_i.other_x[31]}}, item_i.other_x, 1'b0};
  assign oy  = {{2{item_i.other_y[31]}}, item_i.other_y, 1'b0};
  assign hw  = {4'b0, item_i.rect_w};
  assign hh  = {4'b0, item_i.rect_h};
  assign ohw = {4'b0, item_i.other_w};
  assign ohh = {4'b0, item_i.other_h};
  assign rad = {3'b0, item_i.circle_radius, 1'b0};

  assign x_hi = rx + hw;
  assign x_lo = rx - hw;
  assign y_hi = ry + hh;
  assign y_lo = ry - hh;

  // Clamp the circle centre onto the rectangle
  assign cx   = (ox > x_hi) ? x_hi : ox;
  assign cx_c = (cx < x_lo) ? x_lo : cx;
  assign cy   = (oy > y_hi) ? y_hi : oy;
  assign cy_c = (cy < y_lo) ? y_lo : cy;

  assign dx  = ox - cx_c;
  assign dy  = oy - cy_c;
  assign adx = dx[34] ? -dx : dx;
  assign ady = dy[34] ? -dy : dy;

  assign sgn_dx = (dx > 0) ? NormUnit : ((dx < 0) ? -NormUnit : '0);
  assign sgn_dy = (dy > 0) ? NormUnit : ((dy < 0) ? -NormUnit : '0);

  // Centre distances
  assign sx  = ox - rx;
  assign sy  = oy - ry;
  assign asx = sx[34] ? -sx : sx;
  assign asy = sy[34] ? -sy : sy;

  assign pen_cx = hw + rad - asx;
  assign pen_cy = hh + rad - asy;
  assign pen_px = hw + ohw - asx;
  assign pen_py = hh + ohh - asy;

  assign pen_x_raw = item_i.cmd ? pen_px : pen_cx;
  assign pen_y_raw = item_i.cmd ? pen_py : pen_cy;

  always_comb begin
    geo_o.pair     = item_i.cmd;
    geo_o.near     = (adx < rad) && (ady < rad);
    geo_o.pair_hit = (x_hi >= ox - ohw) && (x_lo <= ox + ohw) &&
                     (y_hi >= oy - ohh) && (y_lo <= oy + ohh);
    geo_o.ax       = adx[31:0];
    geo_o.ay       = ady[31:0];
    geo_o.rad      = rad[31:0];
    geo_o.pen_x    = sat_half(pen_x_raw);
    geo_o.pen_y    = sat_half(pen_y_raw);
    if (item_i.cmd) begin
      geo_o.nx = (rx < ox) ? -NormDiag : NormDiag;
      geo_o.ny = (ry < oy) ? -NormDiag : NormDiag;
    end else if (ady > adx) begin
      geo_o.nx = '0;
      geo_o.ny = sgn_dy;
    end else begin
      geo_o.nx = sgn_dx;
      geo_o.ny = '0;
    end
  end

endmodule

`default_nettype wire

>>> design/aabb_circle_collision_test_unit.sv
// Narrow-phase collision unit. Each request on the slave stream is one shape
// pair: tuser selects rectangle versus circle (0) or rectangle versus
// rectangle (1); tdata carries the centres, full sizes and radius in signed
// Q16.16. Each request gives exactly one result on the master stream: tuser
// is the hit flag, tdata holds the normal and the per-axis penetration, all
// zero when there is no hit. Penetration is floored to Q16.16 and saturated
// to 32 bits. The unit takes one request per clock while its output is not
// stalled; each request passes the input register, the clamp and distance
// logic, the three 32x32 squaring multipliers and the 65-bit squared-distance
// compare, each in a stage of its own. A stalled output freezes all stages,
// so s_axis_tready falls only while a result waits and m_axis_tready is low.
// There is no configuration and no kept state between requests.

`default_nettype none

module aabb_circle_collision_test_unit import aabbc_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output      logic                s_axis_tready,
  // from bit 0: rect_x[31:0], rect_y[63:32], rect_w[94:64], rect_h[125:95],
  // other_x[157:126], other_y[189:158], other_w[220:190], other_h[251:221],
  // circle_radius[282:252], zero pad[287:283]
  input  wire logic [InDataW-1:0]  s_axis_tdata,
  // cmd
  input  wire logic                s_axis_tuser,
  output      logic                m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // from bit 0: normal_x[17:0], normal_y[35:18], pen_x[67:36],
  // pen_y[99:68], zero pad[103:100]
  output      logic [OutDataW-1:0] m_axis_tdata,
  // hit
  output      logic                m_axis_tuser
);

  logic advance;

  // Stage valids
  logic in_vld_q, geo_vld_q, prod_vld_q, out_vld_q;

  item_t in_q;
  geo_t  geo_d, geo_q;
  prod_t prod_d, prod_q;

  logic                out_hit_d, out_hit_q;
  logic [OutDataW-1:0] out_data_d, out_data_q;
  logic [64:0]         dist_sq;
  logic                circ_hit;

  // Move every stage together unless a finished result is held up
  assign advance       = !out_vld_q || m_axis_tready;
  assign s_axis_tready = advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q   <= 1'b0;
      geo_vld_q  <= 1'b0;
      prod_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else if (advance) begin
      in_vld_q   <= s_axis_tvalid;
      geo_vld_q  <= in_vld_q;
      prod_vld_q <= geo_vld_q;
      out_vld_q  <= prod_vld_q;
    end
  end

  // Unpack the request into the input register
  always_ff @(posedge clk_i) begin
    if (advance) begin
      in_q.cmd           <= s_axis_tuser;
      in_q.rect_x        <= s_axis_tdata[31:0];
      in_q.rect_y        <= s_axis_tdata[63:32];
      in_q.rect_w        <= s_axis_tdata[94:64];
      in_q.rect_h        <= s_axis_tdata[125:95];
      in_q.other_x       <= s_axis_tdata[157:126];
      in_q.other_y       <= s_axis_tdata[189:158];
      in_q.other_w       <= s_axis_tdata[220:190];
      in_q.other_h       <= s_axis_tdata[251:221];
      in_q.circle_radius <= s_axis_tdata[282:252];
    end
  end

  // Clamp, deltas, normals and penetration
  aabbc_geom u_geom (
    .item_i (in_q),
    .geo_o  (geo_d)
  );

  always_ff @(posedge clk_i) begin
    if (advance) begin
      geo_q <= geo_d;
    end
  end

  // Squares for the circle distance test
  always_comb begin
    prod_d.pair     = geo_q.pair;
    prod_d.near     = geo_q.near;
    prod_d.pair_hit = geo_q.pair_hit;
    prod_d.xx       = 64'(geo_q.ax) * 64'(geo_q.ax);
    prod_d.yy       = 64'(geo_q.ay) * 64'(geo_q.ay);
    prod_d.rr       = 64'(geo_q.rad) * 64'(geo_q.rad);
    prod_d.nx       = geo_q.nx;
    prod_d.ny       = geo_q.ny;
    prod_d.pen_x    = geo_q.pen_x;
    prod_d.pen_y    = geo_q.pen_y;
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      prod_q <= prod_d;
    end
  end

  // Strict compare of the squared distance against the squared radius;
  // with both deltas below the radius, xx < rr already holds
  assign dist_sq  = {1'b0, prod_q.xx} + {1'b0, prod_q.yy};
  assign circ_hit = prod_q.near && (dist_sq < {1'b0, prod_q.rr});

  always_comb begin
    out_hit_d = prod_q.pair ? prod_q.pair_hit : circ_hit;
    if (out_hit_d) begin
      out_data_d = {4'b0, prod_q.pen_y, prod_q.pen_x, prod_q.ny, prod_q.nx};
    end else begin
      out_data_d = '0;
    end
  end

  // Result register: hold while the consumer stalls
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_hit_q  <= out_hit_d;
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_hit_q;
  assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire

>>> design/aabbc_checker.sv
`default_nettype none

`include "aabb_circle_collision_test_unit_assert.svh"

module aabbc_checker import aabbc_pkg::*; (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                s_axis_tvalid,
  input wire logic                s_axis_tready,
  input wire logic                m_axis_tvalid,
  input wire logic                m_axis_tready,
  input wire logic [OutDataW-1:0] m_axis_tdata,
  input wire logic                m_axis_tuser
);

  logic [17:0] nx, ny;

  assign nx = m_axis_tdata[17:0];
  assign ny = m_axis_tdata[35:18];

  // A miss carries no normal and no penetration
  `ACT_ASSERT_NOW(a_miss_zero, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == '0, "miss with nonzero payload")

  // Normal x is zero, a unit or a diagonal
  `ACT_ASSERT_NOW(a_nx_legal, m_axis_tvalid, nx == 18'h00000 || nx == 18'h10000 || nx == 18'h30000 || nx == 18'h0B505 || nx == 18'h34AFB, "illegal normal_x")

  // Accept requests whenever no result is waiting
  `ACT_ASSERT_NOW(a_ready_empty, !m_axis_tvalid && s_axis_tvalid, s_axis_tready, "request refused with empty output")

  // A stalled result holds
  `ACT_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(ny), "stalled result changed")

endmodule

bind aabb_circle_collision_test_unit aabbc_checker u_checker (.*);

`default_nettype wire

>>> sim/aabb_circle_collision_test_unit_tb.sv
module aabb_circle_collision_test_unit_tb;
  import aabbc_pkg::*;

  // Shape selector carried on the slave tuser
  localparam logic CmdCircle = 1'b0;
  localparam logic CmdRect   = 1'b1;

  localparam int          Q           = 65536;   // 1.0 in Q16.16
  localparam int unsigned RandomPairs = 750;
  localparam int unsigned HoldOffLen  = 300;     // long receiver stall
  localparam int unsigned StallLimit  = 5000;    // cycles with no handshake
  localparam int unsigned DrainCycles = 16;

  localparam logic [31:0] SMax = 32'h7FFFFFFF;
  localparam logic [31:0] SMin = 32'h80000000;

  // Expected result, held as raw bit patterns so compares stay unsigned
  typedef struct packed {
    logic        hit;
    logic [17:0] nx;
    logic [17:0] ny;
    logic [31:0] px;
    logic [31:0] py;
  } contact_t;

  // Holds the contact predicted for each accepted request, oldest first
  class contact_scoreboard;
    contact_t    pending[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
    endfunction

    // Floor a Q.17 value to Q16.16 and clip it to 32 bits
    function logic [31:0] half_sat(longint v);
      longint h;
      h = v >>> 1;
      if (h > 64'sd2147483647) return 32'h7FFFFFFF;
      if (h < -64'sd2147483648) return 32'h80000000;
      return h[31:0];
    endfunction

    function contact_t predict_contact(item_t p);
      longint      rx, ry, hw, hh, ox, oy, ohw, ohh, rad;
      longint      cx, cy, dx, dy, adx, ady, sep_x, sep_y;
      logic [63:0] xx, yy, rr;
      contact_t    c;
      c   = '0;
      // Work in Q.17 so that every half size is exact
      rx  = 2 * longint'($signed(p.rect_x));
      ry  = 2 * longint'($signed(p.rect_y));
      ox  = 2 * longint'($signed(p.other_x));
      oy  = 2 * longint'($signed(p.other_y));
      hw  = longint'(p.rect_w);
      hh  = longint'(p.rect_h);
      ohw = longint'(p.other_w);
      ohh = longint'(p.other_h);
      rad = 2 * longint'(p.circle_radius);
      sep_x = (ox > rx) ? ox - rx : rx - ox;
      sep_y = (oy > ry) ? oy - ry : ry - oy;
      if (p.cmd == CmdCircle) begin
        // Clamp the circle centre onto the rectangle
        cx = ox;
        if (cx > rx + hw) cx = rx + hw;
        if (cx < rx - hw) cx = rx - hw;
        cy = oy;
        if (cy > ry + hh) cy = ry + hh;
        if (cy < ry - hh) cy = ry - hh;
        dx  = ox - cx;
        dy  = oy - cy;
        adx = (dx < 0) ? -dx : dx;
        ady = (dy < 0) ? -dy : dy;
        if (adx < rad && ady < rad) begin
          // Squares reach 64 bits; compare them unsigned
          xx = adx * adx;
          yy = ady * ady;
          rr = rad * rad;
          c.hit = (xx < rr) && (yy < rr - xx);
        end
        if (c.hit) begin
          // A tie between the deltas goes to x
          if (ady > adx) c.ny = (dy > 0) ? NormUnit : -NormUnit;
          else if (dx > 0) c.nx = NormUnit;
          else if (dx < 0) c.nx = -NormUnit;
          c.px = half_sat(hw + rad - sep_x);
          c.py = half_sat(hh + rad - sep_y);
        end
      end else begin
        // Touching edges count as overlap
        c.hit = (rx + hw >= ox - ohw) && (rx - hw <= ox + ohw) &&
                (ry + hh >= oy - ohh) && (ry - hh <= oy + ohh);
        if (c.hit) begin
          c.nx = (rx < ox) ? -NormDiag : NormDiag;
          c.ny = (ry < oy) ? -NormDiag : NormDiag;
          c.px = half_sat(hw + ohw - sep_x);
          c.py = half_sat(hh + ohh - sep_y);
        end
      end
      return c;
    endfunction

    function void note_request(item_t p);
      pending.push_back(predict_contact(p));
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(logic hit, logic [OutDataW-1:0] data);
      contact_t want;
      if (pending.size() == 0) begin
        $display("%0t: result with no request waiting, expected none, actual hit %b data %h",
                 $time, hit, data);
        mismatches++;
        return;
      end
      want = pending.pop_front();
      compare_field("hit", 32'(want.hit), 32'(hit));
      compare_field("normal_x", 32'(want.nx), 32'(data[17:0]));
      compare_field("normal_y", 32'(want.ny), 32'(data[35:18]));
      compare_field("pen_x", want.px, data[67:36]);
      compare_field("pen_y", want.py, data[99:68]);
    endfunction
  endclass

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                s_axis_tuser  = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tuser;

  contact_scoreboard scoreboard = new();

  // Shared between the stimulus and the result sink
  logic        steady      = 1'b0;   // suppress idling on both sides
  logic        holdoff_req = 1'b0;   // ask the sink for a long stall
  int unsigned stall_cycles = 0;

  aabb_circle_collision_test_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  // Hold reset, then release it away from the rising edge
  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  function automatic item_t shape_pair(logic cmd, logic [31:0] rx, logic [31:0] ry,
                                       logic [31:0] w, logic [31:0] h,
                                       logic [31:0] ox, logic [31:0] oy,
                                       logic [31:0] ow, logic [31:0] oh,
                                       logic [31:0] r);
    item_t p;
    p.cmd           = cmd;
    p.rect_x        = rx;
    p.rect_y        = ry;
    p.rect_w        = w[30:0];
    p.rect_h        = h[30:0];
    p.other_x       = ox;
    p.other_y       = oy;
    p.other_w       = ow[30:0];
    p.other_h       = oh[30:0];
    p.circle_radius = r[30:0];
    return p;
  endfunction

  // Scatter a value around a base; wrap-around near the extremes is wanted
  function automatic logic [31:0] jitter(logic [31:0] base, int unsigned span);
    return base + $urandom_range(0, 2 * span) - span;
  endfunction

  function automatic logic [31:0] corner_value();
    case ($urandom_range(0, 5))
      0:       return 32'h0;
      1:       return 32'h1;
      2:       return 32'hFFFFFFFF;
      3:       return SMin;
      4:       return SMax;
      default: return $urandom();
    endcase
  endfunction

  // Offer one shape pair and hold it until the unit takes it. Idle cycles
  // drop tvalid; otherwise tvalid stays high from one request to the next.
  task automatic offer_pair(input item_t p);
    while (!steady && $urandom_range(0, 99) < 11) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= p.cmd;
    s_axis_tdata  <= {5'b0, p.circle_radius, p.other_h, p.other_w, p.other_y, p.other_x,
                      p.rect_h, p.rect_w, p.rect_y, p.rect_x};
    do @(posedge clk_i); while (!s_axis_tready);
    scoreboard.note_request(p);
  endtask

  // Result sink: drive tready at the falling edge. A hold-off request keeps
  // tready low for a long stretch, counted here, so the pipe fills and the
  // unit has to push back on its input.
  initial begin : result_sink
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (holdoff_req) begin
        holdoff_req = 1'b0;
        hold_left   = HoldOffLen;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= steady || ($urandom_range(0, 99) >= 11);
      end
    end
  end

  // Check every result taken at the rising edge; watch for a hung stream
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        scoreboard.check_result(m_axis_tuser, m_axis_tdata);
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= StallLimit) begin
        $display("TB_ERROR");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    item_t       pair;
    int unsigned n;
    int unsigned span;
    logic [31:0] bx, by;

    wait (rst_ni);

    // Circle against a 4 x 2 rectangle at the origin
    // centre inside: zero deltas, no normal
    offer_pair(shape_pair(CmdCircle, 0, 0, 4*Q, 2*Q, 0, 0, 0, 0, Q));
    // left, right, above and below the rectangle
    offer_pair(shape_pair(CmdCircle, 0, 0, 4*Q, 2*Q, -(5*Q/2), 0, 0, 0, Q));
    offer_pair(shape_pair(CmdCircle, 0, 0, 4*Q, 2*Q, 5*Q/2, 0, 0, 0, Q));
    offer_pair(shape_pair(CmdCircle, 0, 0, 4*Q, 2*Q, 0, 3*Q/2, 0, 0, Q));
    offer_pair(shape_pair(CmdCircle, 0, 0, 4*Q, 2*Q, 0, -(3*Q/2), 0, 0, Q));
    // distance equal to the radius: the compare is strict
    offer_pair(shape_pair(CmdCircle, 0, 0, 4*Q, 2*Q, 3*Q, 0, 0, 0, Q));
    // corner with equal deltas: the tie picks the x normal
    offer_pair(shape_pair(CmdCircle, 0, 0, 4*Q, 2*Q, 5*Q/2, 3*Q/2, 0, 0, Q));
    // zero radius never hits
    offer_pair(shape_pair(CmdCircle, 0, 0, 4*Q, 2*Q, 0, 0, 0, 0, 0));
    // largest sizes and radius: penetration saturates
    offer_pair(shape_pair(CmdCircle, 0, 0, SMax, SMax, 0, 0, 0, 0, SMax));
    // opposite extremes of the plane
    offer_pair(shape_pair(CmdCircle, SMin, SMin, SMax, SMax, SMax, SMax, SMax, SMax, SMax));
    // zero-size rectangle at the top corner of the plane
    offer_pair(shape_pair(CmdCircle, SMax, SMax, 0, 0, SMax, SMax, 0, 0, 1));
    // all ones in every field
    offer_pair(shape_pair(CmdCircle, '1, '1, '1, '1, '1, '1, '1, '1, '1));

    // Rectangle pairs against the same 4 x 2 rectangle
    offer_pair(shape_pair(CmdRect, 0, 0, 4*Q, 2*Q, Q, Q/2, 2*Q, 2*Q, 0));
    offer_pair(shape_pair(CmdRect, 0, 0, 4*Q, 2*Q, -Q, -(Q/2), 2*Q, 2*Q, 0));
    // equal centres: both normals positive
    offer_pair(shape_pair(CmdRect, 0, 0, 4*Q, 2*Q, 0, 0, 2*Q, 2*Q, 0));
    // edges touching on x, then on y
    offer_pair(shape_pair(CmdRect, 0, 0, 4*Q, 2*Q, 3*Q, 0, 2*Q, 2*Q, 0));
    offer_pair(shape_pair(CmdRect, 0, 0, 4*Q, 2*Q, 0, 2*Q, 2*Q, 2*Q, 0));
    // apart on x only, then on y only
    offer_pair(shape_pair(CmdRect, 0, 0, 4*Q, 2*Q, 7*Q/2, 0, 2*Q, 2*Q, 0));
    offer_pair(shape_pair(CmdRect, 0, 0, 4*Q, 2*Q, 0, 5*Q/2, 2*Q, 2*Q, 0));
    // two points at the same place
    offer_pair(shape_pair(CmdRect, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    // extremes: far apart, then largest overlap
    offer_pair(shape_pair(CmdRect, SMin, SMin, SMax, SMax, SMax, SMax, SMax, SMax, SMax));
    offer_pair(shape_pair(CmdRect, '1, '1, SMax, SMax, 0, 0, SMax, SMax, 0));
    // odd sizes: the half sizes stay exact, the penetration is floored
    offer_pair(shape_pair(CmdRect, 0, 0, 1, 3, 1, 1, 1, 1, 0));

    for (n = 0; n < RandomPairs; n++) begin
      // Stall the sink early on while requests keep coming
      if (n == 100) holdoff_req = 1'b1;
      steady = (n >= 300 && n < 450);
      case ($urandom_range(0, 19))
        0, 1, 2: begin
          pair = shape_pair(1'($urandom_range(0, 1)), $urandom, $urandom, $urandom,
                            $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        end
        3, 4, 5: begin
          pair = shape_pair(1'($urandom_range(0, 1)), corner_value(), corner_value(),
                            corner_value(), corner_value(), corner_value(), corner_value(),
                            corner_value(), corner_value(), corner_value());
        end
        default: begin
          // Clustered shapes at a random scale, so hits and misses both occur
          span = 1 << $urandom_range(2, 26);
          bx   = $urandom;
          by   = $urandom;
          pair = shape_pair(1'($urandom_range(0, 1)), jitter(bx, span), jitter(by, span),
                            $urandom_range(0, 2 * span), $urandom_range(0, 2 * span),
                            jitter(bx, span), jitter(by, span),
                            $urandom_range(0, 2 * span), $urandom_range(0, 2 * span),
                            $urandom_range(0, span));
        end
      endcase
      offer_pair(pair);
    end
    steady = 1'b0;

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;

    // Drain: the watchdog covers a result that never arrives
    while (scoreboard.pending.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (scoreboard.mismatches == 0 && scoreboard.pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+design
design/aabbc_pkg.sv
design/aabbc_geom.sv
design/aabb_circle_collision_test_unit.sv
design/aabbc_checker.sv
sim/aabb_circle_collision_test_unit_tb.sv
